FILE: sv/srlp_pkg.sv
// Shared constants and types for the SIP request line parser.
package srlp_pkg;

    localparam int unsigned MAX_LINE_DEF = 1024;
    localparam int unsigned NUM_METHODS  = 8;
    localparam int unsigned NAME_MAX     = 8;
    localparam int unsigned FIELD_W      = 10;
    localparam int unsigned CODE_W       = 4;

    // Method codes, in match priority order
    localparam logic [CODE_W-1:0] CODE_INVITE   = 4'd0;
    localparam logic [CODE_W-1:0] CODE_ACK      = 4'd1;
    localparam logic [CODE_W-1:0] CODE_BYE      = 4'd2;
    localparam logic [CODE_W-1:0] CODE_REGISTER = 4'd3;
    localparam logic [CODE_W-1:0] CODE_OPTIONS  = 4'd4;
    localparam logic [CODE_W-1:0] CODE_CANCEL   = 4'd5;
    localparam logic [CODE_W-1:0] CODE_UPDATE   = 4'd6;
    localparam logic [CODE_W-1:0] CODE_PRACK    = 4'd7;
    localparam logic [CODE_W-1:0] CODE_UNKNOWN  = 4'd8;

    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_AT    = 8'h40;
    localparam logic [7:0] CHAR_LC_A  = 8'h61;
    localparam logic [7:0] CHAR_LC_Z  = 8'h7A;
    localparam logic [7:0] CASE_FOLD  = 8'h20;

    typedef logic [7:0] t_char;
    typedef logic [NUM_METHODS-1:0] t_mask;

    // Method names, upper case, padded with zero bytes
    localparam t_char METHOD_NAME [NUM_METHODS][NAME_MAX] = '{
        '{"I", "N", "V", "I", "T", "E", 8'h00, 8'h00},
        '{"A", "C", "K", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{"B", "Y", "E", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{"R", "E", "G", "I", "S", "T", "E", "R"},
        '{"O", "P", "T", "I", "O", "N", "S", 8'h00},
        '{"C", "A", "N", "C", "E", "L", 8'h00, 8'h00},
        '{"U", "P", "D", "A", "T", "E", 8'h00, 8'h00},
        '{"P", "R", "A", "C", "K", 8'h00, 8'h00, 8'h00}
    };

    localparam int unsigned METHOD_LEN [NUM_METHODS] = '{6, 3, 3, 8, 7, 6, 6, 5};

    localparam logic [CODE_W-1:0] METHOD_CODE [NUM_METHODS] = '{
        CODE_INVITE, CODE_ACK, CODE_BYE, CODE_REGISTER,
        CODE_OPTIONS, CODE_CANCEL, CODE_UPDATE, CODE_PRACK
    };

endpackage

FILE: sv/srlp_byte_if.sv
// Byte stream channel carrying one request line character per beat.
interface srlp_byte_if;
    logic  valid;
    logic  ready;
    logic [7:0] line_byte;
    logic  last_byte;

    modport source (output valid, output line_byte, output last_byte, input ready);
    modport sink   (input valid, input line_byte, input last_byte, output ready);
endinterface

FILE: sv/srlp_res_if.sv
// Result channel carrying one parsed request line summary per beat.
interface srlp_res_if;
    logic  valid;
    logic  ready;
    logic  parsed;
    logic [srlp_pkg::CODE_W-1:0]  method_code;
    logic [srlp_pkg::FIELD_W-1:0] method_length;
    logic [srlp_pkg::FIELD_W-1:0] uri_start;
    logic [srlp_pkg::FIELD_W-1:0] uri_length;
    logic [srlp_pkg::FIELD_W-1:0] host_start;
    logic [srlp_pkg::FIELD_W-1:0] host_length;

    modport source (
        output valid, output parsed, output method_code, output method_length,
        output uri_start, output uri_length, output host_start, output host_length,
        input ready
    );
    modport sink (
        input valid, input parsed, input method_code, input method_length,
        input uri_start, input uri_length, input host_start, input host_length,
        output ready
    );
endinterface

FILE: sv/sip_request_line_parser.sv
// Top level of the SIP request line parser: byte register, line state and result register.
//
//  Channel  | Dir | Beat payload                                  | Beat rate
//  ---------+-----+-----------------------------------------------+------------------
//  i_byte   | in  | line_byte, last_byte                          | one per cycle
//  o_res    | out | parsed, method_code, method/uri/host offsets  | one per line
//
// A byte is registered on acceptance and then folded into the line state from the byte register;
// a last byte instead loads the result register as it leaves the byte register, and a new line starts.
// Sustained rate is one byte per cycle; the only stall is a last byte sitting in the byte
// register while the previous result is still held in the result register and not taken.
// Reset (synchronous, active low) empties both registers and starts a new line.
module sip_request_line_parser #(
    parameter int unsigned MAX_LINE = srlp_pkg::MAX_LINE_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    srlp_byte_if.sink     i_byte,
    srlp_res_if.source    o_res
);

    localparam int unsigned CNT_W = $clog2(MAX_LINE + 1);
    localparam int unsigned POS_W = $clog2(MAX_LINE);
    localparam int unsigned SUM_W = (CNT_W > srlp_pkg::FIELD_W) ? CNT_W : srlp_pkg::FIELD_W;

    typedef enum logic [1:0] {
        PH_METHOD,
        PH_URI,
        PH_DONE
    } t_phase;

    // Byte register
    logic          r_in_vld;
    srlp_pkg::t_char r_in_byte;
    logic          r_in_last;

    // Line state
    logic [CNT_W-1:0] r_pos,      n_pos;
    t_phase           r_phase,    n_phase;
    srlp_pkg::t_mask  r_mask,     n_mask;
    logic [POS_W-1:0] r_sp1,      n_sp1;
    logic [POS_W-1:0] r_at,       n_at;
    logic             r_at_seen,  n_at_seen;
    logic [POS_W-1:0] r_sp2,      n_sp2;
    logic             r_ovf,      n_ovf;

    // Result register
    logic                                r_out_vld;
    logic                                r_parsed;
    logic [srlp_pkg::CODE_W-1:0]         r_code;
    logic [srlp_pkg::FIELD_W-1:0]        r_mlen, r_ustart, r_ulen, r_hstart, r_hlen;

    logic                                n_parsed;
    logic [srlp_pkg::CODE_W-1:0]         n_code;
    logic [srlp_pkg::FIELD_W-1:0]        n_mlen, n_ustart, n_ulen, n_hstart, n_hlen;

    logic            advance;
    logic            step;
    srlp_pkg::t_char up;
    logic            is_space;
    logic [SUM_W-1:0] sp1_x, sp2_x, at_x;

    // Hold a last byte while the previous result has not been taken
    assign advance = !(r_in_vld && r_in_last) || !r_out_vld || o_res.ready;
    assign step    = r_in_vld && advance;
    assign i_byte.ready = !r_in_vld || advance;

    assign up = ((r_in_byte >= srlp_pkg::CHAR_LC_A) && (r_in_byte <= srlp_pkg::CHAR_LC_Z))
              ? (r_in_byte - srlp_pkg::CASE_FOLD) : r_in_byte;
    assign is_space = (r_in_byte == srlp_pkg::CHAR_SPACE);

    always_comb begin
        n_pos     = r_pos;
        n_phase   = r_phase;
        n_mask    = r_mask;
        n_sp1     = r_sp1;
        n_at      = r_at;
        n_at_seen = r_at_seen;
        n_sp2     = r_sp2;
        n_ovf     = r_ovf;
        if (32'(r_pos) >= MAX_LINE) begin
            // Drop the byte unseen; the line can no longer parse
            n_ovf = 1'b1;
        end else begin
            n_pos = r_pos + CNT_W'(1);
            case (r_phase)
                PH_METHOD: begin
                    if (is_space) begin
                        n_sp1   = r_pos[POS_W-1:0];
                        n_phase = PH_URI;
                        for (int k = 0; k < srlp_pkg::NUM_METHODS; k++) begin
                            if (32'(r_pos) != srlp_pkg::METHOD_LEN[k]) begin
                                n_mask[k] = 1'b0;
                            end
                        end
                    end else begin
                        for (int k = 0; k < srlp_pkg::NUM_METHODS; k++) begin
                            if ((32'(r_pos) >= srlp_pkg::METHOD_LEN[k]) ||
                                (srlp_pkg::METHOD_NAME[k][r_pos[2:0]] != up)) begin
                                n_mask[k] = 1'b0;
                            end
                        end
                    end
                end
                PH_URI: begin
                    if (is_space) begin
                        n_sp2   = r_pos[POS_W-1:0];
                        n_phase = PH_DONE;
                    end else if ((r_in_byte == srlp_pkg::CHAR_AT) && !r_at_seen) begin
                        n_at_seen = 1'b1;
                        n_at      = r_pos[POS_W-1:0];
                    end
                end
                default: begin
                end
            endcase
        end
    end

    assign sp1_x = SUM_W'(n_sp1);
    assign sp2_x = SUM_W'(n_sp2);
    assign at_x  = SUM_W'(n_at);

    // Result from the line state as it stands after this byte
    always_comb begin
        n_parsed = 1'b0;
        n_code   = srlp_pkg::CODE_UNKNOWN;
        n_mlen   = '0;
        n_ustart = '0;
        n_ulen   = '0;
        n_hstart = '0;
        n_hlen   = '0;
        if ((n_phase == PH_DONE) && !n_ovf) begin
            n_parsed = 1'b1;
            for (int k = srlp_pkg::NUM_METHODS - 1; k >= 0; k--) begin
                if (n_mask[k]) begin
                    n_code = srlp_pkg::METHOD_CODE[k];
                end
            end
            n_mlen   = sp1_x[srlp_pkg::FIELD_W-1:0];
            n_ustart = 10'(sp1_x + SUM_W'(1));
            if (n_at_seen) begin
                n_ulen   = 10'(at_x - sp1_x - SUM_W'(1));
                n_hstart = 10'(at_x + SUM_W'(1));
                n_hlen   = 10'(sp2_x - at_x - SUM_W'(1));
            end else begin
                n_ulen   = 10'(sp2_x - sp1_x - SUM_W'(1));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
            r_pos     <= '0;
            r_phase   <= PH_METHOD;
            r_mask    <= '1;
            r_sp1     <= '0;
            r_at      <= '0;
            r_at_seen <= 1'b0;
            r_sp2     <= '0;
            r_ovf     <= 1'b0;
        end else begin
            if (i_byte.ready) begin
                r_in_vld  <= i_byte.valid;
                r_in_byte <= i_byte.line_byte;
                r_in_last <= i_byte.last_byte;
            end
            if (o_res.ready) begin
                r_out_vld <= 1'b0;
            end
            if (step) begin
                if (r_in_last) begin
                    // Start a new line after the last byte
                    r_pos     <= '0;
                    r_phase   <= PH_METHOD;
                    r_mask    <= '1;
                    r_sp1     <= '0;
                    r_at      <= '0;
                    r_at_seen <= 1'b0;
                    r_sp2     <= '0;
                    r_ovf     <= 1'b0;
                    r_out_vld <= 1'b1;
                    r_parsed  <= n_parsed;
                    r_code    <= n_code;
                    r_mlen    <= n_mlen;
                    r_ustart  <= n_ustart;
                    r_ulen    <= n_ulen;
                    r_hstart  <= n_hstart;
                    r_hlen    <= n_hlen;
                end else begin
                    r_pos     <= n_pos;
                    r_phase   <= n_phase;
                    r_mask    <= n_mask;
                    r_sp1     <= n_sp1;
                    r_at      <= n_at;
                    r_at_seen <= n_at_seen;
                    r_sp2     <= n_sp2;
                    r_ovf     <= n_ovf;
                end
            end
        end
    end

    assign o_res.valid         = r_out_vld;
    assign o_res.parsed        = r_parsed;
    assign o_res.method_code   = r_code;
    assign o_res.method_length = r_mlen;
    assign o_res.uri_start     = r_ustart;
    assign o_res.uri_length    = r_ulen;
    assign o_res.host_start    = r_hstart;
    assign o_res.host_length   = r_hlen;

endmodule

FILE: sv/srlp_checker.sv
// Port-level checks for the SIP request line parser, bound to the top level.
module srlp_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_in_ready,
    input logic                          i_out_valid,
    input logic                          i_out_ready,
    input logic                          i_parsed,
    input logic [srlp_pkg::CODE_W-1:0]   i_code,
    input logic [srlp_pkg::FIELD_W-1:0]  i_mlen,
    input logic [srlp_pkg::FIELD_W-1:0]  i_ustart,
    input logic [srlp_pkg::FIELD_W-1:0]  i_ulen,
    input logic [srlp_pkg::FIELD_W-1:0]  i_hstart,
    input logic [srlp_pkg::FIELD_W-1:0]  i_hlen
);

    // A result beat stays offered until it is taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result beat withdrawn before acceptance");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            $stable(i_parsed) && $stable(i_code) && $stable(i_ulen) && $stable(i_hlen))
        else $error("stalled result beat changed");

    // The byte side stalls only behind a full, blocked result register
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in_ready |-> i_out_valid && !i_out_ready)
        else $error("byte input stalled without a blocked result");

    // An unparsed line carries the unknown code and zero offsets
    a_unparsed_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_parsed |->
            (i_code == srlp_pkg::CODE_UNKNOWN) && (i_mlen == '0) && (i_ustart == '0) &&
            (i_ulen == '0) && (i_hstart == '0) && (i_hlen == '0))
        else $error("unparsed result with non-zero fields");

    // The URI begins just past the method token
    a_uri_after_method: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_parsed |-> (i_ustart == i_mlen + srlp_pkg::FIELD_W'(1)))
        else $error("URI start does not follow method token");

endmodule

bind sip_request_line_parser srlp_checker u_srlp_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_byte.ready),
    .i_out_valid (o_res.valid),
    .i_out_ready (o_res.ready),
    .i_parsed    (o_res.parsed),
    .i_code      (o_res.method_code),
    .i_mlen      (o_res.method_length),
    .i_ustart    (o_res.uri_start),
    .i_ulen      (o_res.uri_length),
    .i_hstart    (o_res.host_start),
    .i_hlen      (o_res.host_length)
);
